/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the core RTL. All checks are clocked on clk
// and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/m3i_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, cofactor index tables and types for the 3x3 inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int DATA_W        = 32;
    localparam int THR_W         = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ELEM      = 9;
    localparam int COF_W         = 64;
    localparam int PROD_W        = 96;
    localparam int ACC_W         = 98;
    // quotient bits developed by the divider; anything at 2^33 or above saturates
    localparam int QUOT_W        = 33;
    // abs stage, setup stage, one stage per quotient bit, output stage
    localparam int LANE_LAT      = QUOT_W + 3;

    // smallest nonzero magnitude, one LSB of the determinant format
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // element order: 0=m00 1=m01 2=m02 3=m10 4=m11 5=m12 6=m20 7=m21 8=m22
    // cofactor k = m[A]*m[B] - m[C]*m[D], in row-major order of the adjugate
    localparam int COF_A [NUM_ELEM] = '{4, 2, 1, 6, 0, 3, 3, 6, 0};
    localparam int COF_B [NUM_ELEM] = '{8, 7, 5, 5, 8, 2, 7, 1, 4};
    localparam int COF_C [NUM_ELEM] = '{5, 1, 4, 3, 6, 0, 6, 0, 1};
    localparam int COF_D [NUM_ELEM] = '{7, 8, 2, 8, 2, 5, 4, 7, 3};
    // determinant = first row times first column of the adjugate
    localparam int DET_COF [3] = '{0, 3, 6};

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] det;
    } det_res_t;

endpackage

/* rtl/core/matrix3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 inverse by the adjugate method in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive m00..m22 and pulse start; an item is taken at every edge
//   with start high. busy is always low, so a matrix may enter every cycle.
//   Output: done is high for one cycle with r00..r22, determinant and
//   near_singular. The receiver cannot stall and none is needed: the
//   pipeline never backs up.
//   Path: the accepting edge feeds the cofactor and determinant pipeline,
//   then the divider lanes (absolute value, setup, one stage per quotient
//   bit over 33 bits, and output saturation), whose last register drives
//   done. Throughput: one matrix per cycle.
//   Config: cfg_we writes cfg_wdata into the near-singular threshold, in
//   the same fixed-point format as the determinant; write it only while no
//   item is in flight.
//   Reset: clears all valid bits (in-flight items are dropped) and sets the
//   threshold to one LSB.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [m3i_pkg::THR_W-1:0]         cfg_wdata,
    input  logic signed [m3i_pkg::DATA_W-1:0] m00,
    input  logic signed [m3i_pkg::DATA_W-1:0] m01,
    input  logic signed [m3i_pkg::DATA_W-1:0] m02,
    input  logic signed [m3i_pkg::DATA_W-1:0] m10,
    input  logic signed [m3i_pkg::DATA_W-1:0] m11,
    input  logic signed [m3i_pkg::DATA_W-1:0] m12,
    input  logic signed [m3i_pkg::DATA_W-1:0] m20,
    input  logic signed [m3i_pkg::DATA_W-1:0] m21,
    input  logic signed [m3i_pkg::DATA_W-1:0] m22,
    output logic                              done,
    output logic signed [m3i_pkg::DATA_W-1:0] r00,
    output logic signed [m3i_pkg::DATA_W-1:0] r01,
    output logic signed [m3i_pkg::DATA_W-1:0] r02,
    output logic signed [m3i_pkg::DATA_W-1:0] r10,
    output logic signed [m3i_pkg::DATA_W-1:0] r11,
    output logic signed [m3i_pkg::DATA_W-1:0] r12,
    output logic signed [m3i_pkg::DATA_W-1:0] r20,
    output logic signed [m3i_pkg::DATA_W-1:0] r21,
    output logic signed [m3i_pkg::DATA_W-1:0] r22,
    output logic signed [m3i_pkg::DATA_W-1:0] determinant,
    output logic                              near_singular
);

    localparam int N   = m3i_pkg::NUM_ELEM;
    localparam int W   = m3i_pkg::DATA_W;
    localparam int LAT = m3i_pkg::LANE_LAT;

    logic [m3i_pkg::THR_W-1:0] thr_reg;
    m3i_pkg::elem_t            m   [N];
    m3i_pkg::cof_t             cof [N];
    m3i_pkg::det_res_t         dres;
    logic signed [W-1:0]       quot [N];
    logic [N-1:0]              lane_v;
    logic [W-1:0]              mag;
    logic                      near_now;
    logic signed [W-1:0]       dly_det_reg  [LAT];
    logic                      dly_near_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= m3i_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    assign m[0] = m00;
    assign m[1] = m01;
    assign m[2] = m02;
    assign m[3] = m10;
    assign m[4] = m11;
    assign m[5] = m12;
    assign m[6] = m20;
    assign m[7] = m21;
    assign m[8] = m22;

    m3i_det #(
        .FRAC_BITS (FRAC_BITS)
    ) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .m        (m),
        .res      (dres),
        .cof_out  (cof)
    );

    for (genvar k = 0; k < N; k++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dres.valid),
            .cof       (cof[k]),
            .dv        (dres.det),
            .out_valid (lane_v[k]),
            .quot      (quot[k])
        );
    end

    assign mag      = dres.det[W-1] ? W'(-dres.det) : W'(dres.det);
    assign near_now = (mag < {1'b0, thr_reg});

    // determinant and flag ride alongside the divider lanes
    always_ff @(posedge clk)
    begin
        dly_det_reg[0]  <= dres.det;
        dly_near_reg[0] <= near_now;
    end

    for (genvar s = 1; s < LAT; s++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            dly_det_reg[s]  <= dly_det_reg[s-1];
            dly_near_reg[s] <= dly_near_reg[s-1];
        end
    end

    assign busy          = 1'b0;
    assign done          = lane_v[0];
    assign r00           = quot[0];
    assign r01           = quot[1];
    assign r02           = quot[2];
    assign r10           = quot[3];
    assign r11           = quot[4];
    assign r12           = quot[5];
    assign r20           = quot[6];
    assign r21           = quot[7];
    assign r22           = quot[8];
    assign determinant   = dly_det_reg[LAT-1];
    assign near_singular = dly_near_reg[LAT-1];

    `ASSERT_IMPL(a_lanes_aligned, 1'b1, lane_v == {N{lane_v[0]}},
        "divider lanes out of step")
    `ASSERT_IMPL(a_zero_det, done && determinant == '0,
        r00 == '0 && r01 == '0 && r02 == '0 && r10 == '0 && r11 == '0
        && r12 == '0 && r20 == '0 && r21 == '0 && r22 == '0,
        "zero determinant gave a nonzero inverse")

endmodule

/* rtl/core/m3i_det.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det
// Six-stage pipeline: nine exact 2x2 cofactors and the rounded, saturated
// determinant. Cofactors leave aligned with the determinant.
// ----------------------------------------------------------------------------
module m3i_det #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  m3i_pkg::elem_t      m [m3i_pkg::NUM_ELEM],
    output m3i_pkg::det_res_t   res,
    output m3i_pkg::cof_t       cof_out [m3i_pkg::NUM_ELEM]
);

    localparam int N = m3i_pkg::NUM_ELEM;
    localparam int W = m3i_pkg::DATA_W;
    localparam logic signed [m3i_pkg::ACC_W-1:0] HALF =
        m3i_pkg::ACC_W'(1) <<< (2*FRAC_BITS-1);

    logic [6:1] v_reg;

    logic signed [m3i_pkg::COF_W-1:0]  pa_reg [N];
    logic signed [m3i_pkg::COF_W-1:0]  pb_reg [N];
    m3i_pkg::elem_t                    e1_reg [3];
    m3i_pkg::elem_t                    e2_reg [3];
    m3i_pkg::cof_t                     cof2_reg [N];
    m3i_pkg::cof_t                     cof3_reg [N];
    m3i_pkg::cof_t                     cof4_reg [N];
    m3i_pkg::cof_t                     cof5_reg [N];
    m3i_pkg::cof_t                     cof6_reg [N];
    logic signed [m3i_pkg::COF_W-1:0]  ph_reg [3];
    logic signed [m3i_pkg::COF_W:0]    pl_reg [3];
    logic signed [m3i_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [m3i_pkg::ACC_W-1:0]  acc_reg;
    logic signed [m3i_pkg::ACC_W-1:0]  shifted;
    logic signed [W-1:0]               det_next;
    logic signed [W-1:0]               det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_cof
        always_ff @(posedge clk)
        begin
            pa_reg[k]   <= m[m3i_pkg::COF_A[k]] * m[m3i_pkg::COF_B[k]];
            pb_reg[k]   <= m[m3i_pkg::COF_C[k]] * m[m3i_pkg::COF_D[k]];
            cof2_reg[k] <= pa_reg[k] - pb_reg[k];
            cof3_reg[k] <= cof2_reg[k];
            cof4_reg[k] <= cof3_reg[k];
            cof5_reg[k] <= cof4_reg[k];
            cof6_reg[k] <= cof5_reg[k];
        end
        assign cof_out[k] = cof6_reg[k];
    end

    // 64 x 32 products split into a signed high half and an unsigned low half
    for (genvar j = 0; j < 3; j++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            e1_reg[j]   <= m[j];
            e2_reg[j]   <= e1_reg[j];
            ph_reg[j]   <= $signed(cof2_reg[m3i_pkg::DET_COF[j]][m3i_pkg::COF_W-1:W]) * e2_reg[j];
            pl_reg[j]   <= $signed({1'b0, cof2_reg[m3i_pkg::DET_COF[j]][W-1:0]}) * e2_reg[j];
            prod_reg[j] <= {ph_reg[j], {W{1'b0}}}
                           + {{(m3i_pkg::PROD_W-m3i_pkg::COF_W-1){pl_reg[j][m3i_pkg::COF_W]}},
                              pl_reg[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= m3i_pkg::ACC_W'(prod_reg[0]) + m3i_pkg::ACC_W'(prod_reg[1])
                   + m3i_pkg::ACC_W'(prod_reg[2]) + HALF;
        det_reg <= det_next;
    end

    // round half up: floor after adding half a step
    assign shifted = acc_reg >>> (2*FRAC_BITS);

    always_comb
    begin
        priority if (shifted > m3i_pkg::SAT_HI)
            det_next = m3i_pkg::SAT_HI[W-1:0];
        else if (shifted < m3i_pkg::SAT_LO)
            det_next = m3i_pkg::SAT_LO[W-1:0];
        else
            det_next = shifted[W-1:0];
    end

    assign res.valid = v_reg[6];
    assign res.det   = det_reg;

endmodule

/* rtl/core/m3i_div_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider: cofactor / determinant, truncated toward
// zero, saturated to 32 bits, forced to zero for a zero divisor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m3i_div_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  m3i_pkg::cof_t                    cof,
    input  logic signed [m3i_pkg::DATA_W-1:0] dv,
    output logic                             out_valid,
    output logic signed [m3i_pkg::DATA_W-1:0] quot
);

    localparam int W  = m3i_pkg::DATA_W;
    localparam int CW = m3i_pkg::COF_W;
    localparam int QW = m3i_pkg::QUOT_W;

    typedef struct packed {
        logic neg;
        logic zero;
        logic ovf;
    } div_ctl_t;

    logic                v_a_reg;
    logic [CW-1:0]       cm_a_reg;
    logic [W-1:0]        dm_a_reg;
    logic                neg_a_reg;
    logic                zero_a_reg;
    logic [CW-1:0]       cm_a_next;
    logic [W-1:0]        dm_a_next;

    logic                v_reg   [QW+1];
    div_ctl_t            ctl_reg [QW+1];
    logic [W-1:0]        rem_reg [QW+1];
    logic [QW-1:0]       q_reg   [QW+1];
    logic [QW-1:0]       lo_reg  [QW+1];
    logic [W-1:0]        dm_reg  [QW+1];

    logic                out_valid_reg;
    logic signed [W-1:0] quot_reg;
    logic signed [W-1:0] quot_next;
    logic                big;

    assign cm_a_next = cof[CW-1] ? CW'(-cof) : CW'(cof);
    assign dm_a_next = dv[W-1] ? W'(-dv) : W'(dv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg  <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_a_reg  <= in_valid;
            v_reg[0] <= v_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cm_a_reg    <= cm_a_next;
        dm_a_reg    <= dm_a_next;
        neg_a_reg   <= cof[CW-1] ^ dv[W-1];
        zero_a_reg  <= (dv == '0);
        // high part already >= divisor: quotient is at least 2^33
        ctl_reg[0]  <= '{neg: neg_a_reg, zero: zero_a_reg,
                         ovf: ({1'b0, cm_a_reg[CW-1:QW]} >= dm_a_reg)};
        rem_reg[0]  <= {1'b0, cm_a_reg[CW-1:QW]};
        lo_reg[0]   <= cm_a_reg[QW-1:0];
        q_reg[0]    <= '0;
        dm_reg[0]   <= dm_a_reg;
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_step
        logic [W:0] trial;
        logic       ge;

        assign trial = {rem_reg[s-1], lo_reg[s-1][QW-s]};
        assign ge    = (trial >= {1'b0, dm_reg[s-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_reg[s] <= ctl_reg[s-1];
            rem_reg[s] <= ge ? W'(trial - {1'b0, dm_reg[s-1]}) : trial[W-1:0];
            q_reg[s]   <= {q_reg[s-1][QW-2:0], ge};
            lo_reg[s]  <= lo_reg[s-1];
            dm_reg[s]  <= dm_reg[s-1];
        end
    end

    assign big = ctl_reg[QW].ovf | q_reg[QW][QW-1];

    always_comb
    begin
        priority if (ctl_reg[QW].zero)
            quot_next = '0;
        else if (ctl_reg[QW].neg)
            quot_next = (big || (q_reg[QW][W-1] && (q_reg[QW][W-2:0] != '0)))
                        ? {1'b1, {(W-1){1'b0}}} : W'(-q_reg[QW][W-1:0]);
        else
            quot_next = (big || q_reg[QW][W-1]) ? {1'b0, {(W-1){1'b1}}} : q_reg[QW][W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;

    `ASSERT_NEXT(a_zero_div, v_reg[QW] && ctl_reg[QW].zero, quot_reg == '0,
        "zero divisor gave a nonzero quotient")
    `ASSERT_NEXT(a_neg_sign, v_reg[QW] && ctl_reg[QW].neg && !ctl_reg[QW].zero,
        quot_reg[W-1] || quot_reg == '0, "negative quotient lost its sign")
    `ASSERT_NEXT(a_pos_sign, v_reg[QW] && !ctl_reg[QW].neg, !quot_reg[W-1],
        "positive quotient came out negative")

endmodule

/* tb/matrix3_inverse_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb
// Drives 3x3 matrices into the adjugate inverse core and checks each result
// against a predictor kept in the bench. Runs directed corner matrices, then
// random matrices under several threshold settings, random start gaps outside a calm window.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

    localparam int FB = m3i_pkg::FRAC_BITS_DEF;
    localparam int DRAIN = 60;

    typedef struct {
        m3i_pkg::elem_t r [m3i_pkg::NUM_ELEM];
        m3i_pkg::elem_t det;
        logic           ns;
    } inv_res_t;

    class inverse_scoreboard;
        logic [m3i_pkg::THR_W-1:0] thr;
        inv_res_t pending [$];
        int errors;

        function new();
            thr = m3i_pkg::THR_RESET;
            errors = 0;
        endfunction

        function m3i_pkg::elem_t sat32(logic signed [127:0] v);
            if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
            if (v < -128'sh80000000) return 32'sh80000000;
            return m3i_pkg::elem_t'(v);
        endfunction

        function void note_matrix(m3i_pkg::elem_t m [m3i_pkg::NUM_ELEM]);
            logic signed [127:0] c [m3i_pkg::NUM_ELEM];
            logic signed [127:0] acc;
            logic signed [127:0] q;
            logic [31:0] mag;
            inv_res_t e;
            for (int k = 0; k < m3i_pkg::NUM_ELEM; k++)
            begin
                c[k] = 128'(m[m3i_pkg::COF_A[k]]) * 128'(m[m3i_pkg::COF_B[k]])
                     - 128'(m[m3i_pkg::COF_C[k]]) * 128'(m[m3i_pkg::COF_D[k]]);
            end
            acc = c[0] * 128'(m[0]) + c[3] * 128'(m[1]) + c[6] * 128'(m[2]);
            acc = (acc + (128'sd1 <<< (2*FB - 1))) >>> (2*FB);
            e.det = sat32(acc);
            for (int k = 0; k < m3i_pkg::NUM_ELEM; k++)
            begin
                if (e.det == 0)
                    e.r[k] = '0;
                else
                begin
                    q = c[k] / 128'(e.det);   // truncates toward zero
                    e.r[k] = sat32(q);
                end
            end
            mag = (e.det < 0) ? 32'(-64'(e.det)) : 32'(e.det);
            e.ns = (mag < {1'b0, thr});
            pending.push_back(e);
        endfunction

        function void check_result(m3i_pkg::elem_t r [m3i_pkg::NUM_ELEM],
                                   m3i_pkg::elem_t det, logic ns);
            inv_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result det=%h", $time, det);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < m3i_pkg::NUM_ELEM; k++)
                if (r[k] !== e.r[k])
                begin
                    $display("%0t: r[%0d] expected %h actual %h", $time, k, e.r[k], r[k]);
                    errors++;
                end
            if (det !== e.det)
            begin
                $display("%0t: determinant expected %h actual %h", $time, e.det, det);
                errors++;
            end
            if (ns !== e.ns)
            begin
                $display("%0t: near_singular expected %b actual %b", $time, e.ns, ns);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, cfg_we, done, near_singular;
    logic [m3i_pkg::THR_W-1:0] cfg_wdata;
    m3i_pkg::elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    m3i_pkg::elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant;

    inverse_scoreboard sb;
    bit calm;

    matrix3_inverse dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .done(done), .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
        .r12(r12), .r20(r20), .r21(r21), .r22(r22),
        .determinant(determinant), .near_singular(near_singular)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("** matrix3_inverse: FAILED **");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        m3i_pkg::elem_t r [m3i_pkg::NUM_ELEM];
        if (rst_n && done)
        begin
            r = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            sb.check_result(r, determinant, near_singular);
        end
    end

    task automatic send_matrix(m3i_pkg::elem_t m [m3i_pkg::NUM_ELEM]);
        while (!calm && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_matrix(m);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_threshold(logic [m3i_pkg::THR_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.thr = v;
    endtask

    function automatic m3i_pkg::elem_t rand_elem(int style);
        case (style)
            0: return m3i_pkg::elem_t'($urandom);
            1: return m3i_pkg::elem_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            2: return m3i_pkg::elem_t'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
            3: return m3i_pkg::elem_t'($signed($urandom_range(0, 64)) - 32);
            default:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return '0;
                    default: return 32'sh00010000;
                endcase
            end
        endcase
    endfunction

    initial
    begin
        m3i_pkg::elem_t m [m3i_pkg::NUM_ELEM];
        logic [m3i_pkg::THR_W-1:0] thr_set [5];
        int style;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaled identity, zero, extremes, singular rows
        m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
        send_matrix(m);
        m = '{32'sh20000, 0, 0, 0, 32'sh20000, 0, 0, 0, 32'sh20000};
        send_matrix(m);
        m = '{32'sh100, 0, 0, 0, 32'sh100, 0, 0, 0, 32'sh100};   // tiny det
        send_matrix(m);
        m = '{default: 0};
        send_matrix(m);
        m = '{default: 32'sh7FFFFFFF};
        send_matrix(m);
        m = '{default: 32'sh80000000};
        send_matrix(m);
        m = '{32'sh80000000, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000};
        send_matrix(m);   // determinant overflow
        m = '{1, 2, 3, 2, 4, 6, 7, 8, 9};                          // singular
        send_matrix(m);
        m = '{32'sh10000, 32'sh20000, 32'sh30000, 0, 32'sh10000, 32'sh40000,
              32'sh50000, 32'sh60000, 0};
        send_matrix(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_matrix(m);
        m = '{32'shFFFF0000, 0, 0, 0, 32'shFFFF0000, 0, 0, 0, 32'shFFFF0000};
        send_matrix(m);
        m = '{32'sh8000, 0, 0, 0, 32'sh8000, 0, 0, 0, 32'sh8000};  // det one eighth
        send_matrix(m);
        m = '{32'sh7FFFFFFF, 1, 0, 32'sh80000000, 1, 0, 0, 0, 32'sh10000};
        send_matrix(m);
        drain();

        thr_set = '{31'h7FFFFFFF, 31'd0, 31'h00010000, 31'h00000400,
                    m3i_pkg::THR_RESET};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thr_set[ph]);
            for (int n = 0; n < 380; n++)
            begin
                calm = (n >= 150 && n < 230);
                style = $urandom_range(0, 9);
                style = (style < 2) ? 0 : (style < 5) ? 1 : (style < 7) ? 2 :
                        (style < 9) ? 3 : 4;
                for (int k = 0; k < m3i_pkg::NUM_ELEM; k++)
                    m[k] = rand_elem(style);
                if ($urandom_range(9) == 0)   // force a dependent row
                    for (int k = 0; k < 3; k++)
                        m[6 + k] = m[k];
                send_matrix(m);
            end
            calm = 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("** matrix3_inverse: PASSED **");
        else
            $display("** matrix3_inverse: FAILED **");
        $finish;
    end
endmodule
